// ===== rtl/pisc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor coverage test package
// Shared widths, register and mode codes, chain cell types and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package pisc_pkg;

  localparam int COORD_WIDTH_DEF   = 24;
  localparam int ANGLE_WIDTH_DEF   = 18;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int RANGE_W    = 23;
  localparam int MODE_W     = 2;
  localparam int NORM_W     = 30;
  localparam int FRAC_EXTRA = 5;
  localparam int CW         = 34;
  localparam int ZW         = 22;
  localparam int AW         = 18;
  localparam int SQ_W       = 62;
  localparam int SQ_STAGES  = SQ_W / 2;
  localparam int ANG_PI     = 1 << 20;
  localparam int ANG_HALF   = 32768;

  localparam int RANGE_NEAR_RST   = 102;
  localparam int RANGE_FAR_RST    = 10240;
  localparam int SECOND_ANGLE_RST = 65536;

  typedef enum logic [2:0] {
    REG_SENSOR_X     = 3'd0,
    REG_SENSOR_Y     = 3'd1,
    REG_SENSOR_Z     = 3'd2,
    REG_RANGE_NEAR   = 3'd3,
    REG_RANGE_FAR    = 3'd4,
    REG_MODE         = 3'd5,
    REG_FIRST_ANGLE  = 3'd6,
    REG_SECOND_ANGLE = 3'd7
  } reg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_SPHERE = 2'd0,
    MODE_SECTOR = 2'd1,
    MODE_CONE   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [ZW-1:0] z;
  } cord_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = ZW'(262144);
      1:       v = ZW'(154753);
      2:       v = ZW'(81767);
      3:       v = ZW'(41506);
      4:       v = ZW'(20834);
      5:       v = ZW'(10427);
      6:       v = ZW'(5215);
      7:       v = ZW'(2608);
      8:       v = ZW'(1304);
      9:       v = ZW'(652);
      10:      v = ZW'(326);
      11:      v = ZW'(163);
      12:      v = ZW'(81);
      13:      v = ZW'(41);
      14:      v = ZW'(20);
      15:      v = ZW'(10);
      16:      v = ZW'(5);
      17:      v = ZW'(3);
      18:      v = ZW'(1);
      19:      v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/pisc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One registered bit step of a restoring integer square root.
// ----------------------------------------------------------------------------
module pisc_sqrt_cell import pisc_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic  clk_i,
  input  sqrt_t in_i,
  output sqrt_t out_o
);

  localparam logic [SQ_W-1:0] ONE = SQ_W'(1) << (2 * BIT);

  sqrt_t out_d, out_q;
  logic [SQ_W-1:0] trial;

  always_comb begin
    trial = in_i.res + ONE;
    if (in_i.rem >= trial) begin
      out_d.rem = in_i.rem - trial;
      out_d.res = (in_i.res >> 1) + ONE;
    end else begin
      out_d.rem = in_i.rem;
      out_d.res = in_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

// ===== rtl/pisc_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC cell
// One registered vectoring rotation, driving y toward zero.
// ----------------------------------------------------------------------------
module pisc_cordic_cell import pisc_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic  clk_i,
  input  cord_t in_i,
  output cord_t out_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_entry(STAGE);

  cord_t out_d, out_q;
  logic signed [CW-1:0] x, y, tx, ty;
  logic signed [ZW-1:0] z;

  always_comb begin
    x  = $signed(in_i.x);
    y  = $signed(in_i.y);
    z  = $signed(in_i.z);
    tx = x >>> STAGE;
    ty = y >>> STAGE;
    if (y < 0) begin
      out_d.x = x - ty;
      out_d.y = y + tx;
      out_d.z = z - ATAN;
    end else begin
      out_d.x = x + ty;
      out_d.y = y - tx;
      out_d.z = z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

// ===== rtl/point_in_sensor_coverage_unit.sv =====
// ----------------------------------------------------------------------------
// Point in sensor coverage unit
// Tests one 3D point per cycle against the range shell and the sector or
// cone limits of a sensor.
// ----------------------------------------------------------------------------
// Pipeline: done_o strobes once the result has passed the input stages, the
// 31-cell square root chain, the CORDIC cell chain and the output registers.
// Throughput: one word per cycle; busy_o stays low and results cannot stall.
// Reset clears the valid pipeline and loads the register defaults.
module point_in_sensor_coverage_unit import pisc_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  localparam int CFG_W0 = (COORD_WIDTH > RANGE_W) ? COORD_WIDTH : RANGE_W,
  localparam int CFG_W  = (CFG_W0 > ANGLE_WIDTH) ? CFG_W0 : ANGLE_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  output logic                          done_o,
  output logic                          covered_o
);

  localparam int DW     = COORD_WIDTH + 1;
  localparam int MW     = COORD_WIDTH;
  localparam int SH_MAX = (COORD_WIDTH > NORM_W) ? COORD_WIDTH - NORM_W : 0;
  localparam int SH_W   = $clog2(SH_MAX + 2);
  localparam int D2_W   = 2 * MW + 2;
  localparam int RQ_W   = 2 * RANGE_W;
  localparam int CMPR_W = (D2_W > RQ_W) ? D2_W : RQ_W;
  localparam int CMPA_W = ((ANGLE_WIDTH > AW) ? ANGLE_WIDTH : AW) + 1;
  localparam int LAT    = 7 + SQ_STAGES + CORDIC_STAGES;

  typedef struct packed {
    logic              sx;
    logic              sy;
    logic              sz;
    logic [NORM_W-1:0] mx;
    logic [NORM_W-1:0] my;
    logic [NORM_W-1:0] mz;
  } side_t;

  typedef struct packed {
    logic inr;
    logic h_zero;
    logic h_xneg;
    logic h_ypos;
    logic v_zero;
  } tag_t;

  // Configuration registers
  logic signed [COORD_WIDTH-1:0] sensor_x_q, sensor_y_q, sensor_z_q;
  logic [RQ_W-1:0]               near_sq_q, far_sq_q;
  logic [MODE_W-1:0]             mode_q;
  logic signed [ANGLE_WIDTH-1:0] first_angle_q, second_angle_q;
  logic [RQ_W-1:0]               cfg_sq;

  assign cfg_sq = RQ_W'(cfg_data_i[RANGE_W-1:0]) * RQ_W'(cfg_data_i[RANGE_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_x_q     <= '0;
      sensor_y_q     <= '0;
      sensor_z_q     <= '0;
      near_sq_q      <= RQ_W'(RANGE_NEAR_RST * RANGE_NEAR_RST);
      far_sq_q       <= RQ_W'(RANGE_FAR_RST * RANGE_FAR_RST);
      mode_q         <= MODE_SECTOR;
      first_angle_q  <= '0;
      second_angle_q <= ANGLE_WIDTH'(SECOND_ANGLE_RST);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SENSOR_X:     sensor_x_q     <= cfg_data_i[COORD_WIDTH-1:0];
        REG_SENSOR_Y:     sensor_y_q     <= cfg_data_i[COORD_WIDTH-1:0];
        REG_SENSOR_Z:     sensor_z_q     <= cfg_data_i[COORD_WIDTH-1:0];
        REG_RANGE_NEAR:   near_sq_q      <= cfg_sq;
        REG_RANGE_FAR:    far_sq_q       <= cfg_sq;
        REG_MODE:         mode_q         <= cfg_data_i[MODE_W-1:0];
        REG_FIRST_ANGLE:  first_angle_q  <= cfg_data_i[ANGLE_WIDTH-1:0];
        REG_SECOND_ANGLE: second_angle_q <= cfg_data_i[ANGLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Valid pipeline
  logic v1_q, v2_q, v3_q, v4_q, v5_q, f1_vld_q, done_q;
  logic [SQ_STAGES-1:0]     vld_sq_q;
  logic [CORDIC_STAGES-1:0] vld_cd_q;
  logic                     covered_d, covered_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      vld_sq_q  <= '0;
      vld_cd_q  <= '0;
      f1_vld_q  <= 1'b0;
      done_q    <= 1'b0;
      covered_q <= 1'b0;
    end else begin
      v1_q      <= start_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      vld_sq_q  <= {vld_sq_q[SQ_STAGES-2:0], v5_q};
      vld_cd_q  <= {vld_cd_q[CORDIC_STAGES-2:0], vld_sq_q[SQ_STAGES-1]};
      f1_vld_q  <= vld_cd_q[CORDIC_STAGES-1];
      done_q    <= f1_vld_q;
      covered_q <= covered_d;
    end
  end

  // Stages 1 to 5: offsets, magnitudes, squares, normalizing, range test
  logic [DW-1:0]      dx_q, dy_q, dz_q;
  logic [DW-1:0]      nx, ny, nz;
  logic [MW-1:0]      mx_q, my_q, mz_q;
  logic               sx_q, sy_q, sz_q;
  logic [2*MW-1:0]    sqx_q, sqy_q, sqz_q;
  logic [MW-1:0]      mmax;
  logic [63:0]        mmax64, shx, shy, shz;
  logic [SH_W-1:0]    shamt;
  side_t              side3_d, side3_q, side4_q, side5_q;
  logic [D2_W-1:0]    d2_q;
  logic [2*NORM_W-1:0] nsqx_q, nsqy_q;
  logic [SQ_W-1:0]    n_q;
  logic               inr_q;

  assign nx = DW'(0) - dx_q;
  assign ny = DW'(0) - dy_q;
  assign nz = DW'(0) - dz_q;

  always_comb begin
    mmax = mx_q;
    if (my_q > mmax) begin
      mmax = my_q;
    end
    if (mz_q > mmax) begin
      mmax = mz_q;
    end
    mmax64 = 64'(mmax);
    shamt  = '0;
    for (int k = 1; k <= SH_MAX; k++) begin
      if ((mmax64 >> (k - 1)) >= (64'(1) << NORM_W)) begin
        shamt = SH_W'(k);
      end
    end
    shx = 64'(mx_q) >> shamt;
    shy = 64'(my_q) >> shamt;
    shz = 64'(mz_q) >> shamt;
    side3_d.mx = shx[NORM_W-1:0];
    side3_d.my = shy[NORM_W-1:0];
    side3_d.mz = shz[NORM_W-1:0];
    side3_d.sx = sx_q && (shx[NORM_W-1:0] != '0);
    side3_d.sy = sy_q && (shy[NORM_W-1:0] != '0);
    side3_d.sz = sz_q && (shz[NORM_W-1:0] != '0);
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= {point_x_i[COORD_WIDTH-1], point_x_i} - {sensor_x_q[COORD_WIDTH-1], sensor_x_q};
    dy_q    <= {point_y_i[COORD_WIDTH-1], point_y_i} - {sensor_y_q[COORD_WIDTH-1], sensor_y_q};
    dz_q    <= {point_z_i[COORD_WIDTH-1], point_z_i} - {sensor_z_q[COORD_WIDTH-1], sensor_z_q};
    mx_q    <= dx_q[DW-1] ? nx[MW-1:0] : dx_q[MW-1:0];
    my_q    <= dy_q[DW-1] ? ny[MW-1:0] : dy_q[MW-1:0];
    mz_q    <= dz_q[DW-1] ? nz[MW-1:0] : dz_q[MW-1:0];
    sx_q    <= dx_q[DW-1];
    sy_q    <= dy_q[DW-1];
    sz_q    <= dz_q[DW-1];
    sqx_q   <= (2*MW)'(mx_q) * (2*MW)'(mx_q);
    sqy_q   <= (2*MW)'(my_q) * (2*MW)'(my_q);
    sqz_q   <= (2*MW)'(mz_q) * (2*MW)'(mz_q);
    side3_q <= side3_d;
    d2_q    <= D2_W'(sqx_q) + D2_W'(sqy_q) + D2_W'(sqz_q);
    nsqx_q  <= (2*NORM_W)'(side3_q.mx) * (2*NORM_W)'(side3_q.mx);
    nsqy_q  <= (2*NORM_W)'(side3_q.my) * (2*NORM_W)'(side3_q.my);
    side4_q <= side3_q;
    n_q     <= SQ_W'(nsqx_q) + SQ_W'(nsqy_q);
    inr_q   <= (CMPR_W'(d2_q) >= CMPR_W'(near_sq_q)) && (CMPR_W'(d2_q) <= CMPR_W'(far_sq_q));
    side5_q <= side4_q;
  end

  // Square root chain for the horizontal radius
  sqrt_t sq_chain [SQ_STAGES+1];
  side_t side_line_q [SQ_STAGES];
  logic [SQ_STAGES-1:0] inr_sq_q;

  assign sq_chain[0] = '{rem: n_q, res: '0};

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    pisc_sqrt_cell #(
      .BIT(SQ_STAGES - 1 - k)
    ) u_cell (
      .clk_i(clk_i),
      .in_i (sq_chain[k]),
      .out_o(sq_chain[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    side_line_q[0] <= side5_q;
    for (int k = 1; k < SQ_STAGES; k++) begin
      side_line_q[k] <= side_line_q[k-1];
    end
    inr_sq_q <= {inr_sq_q[SQ_STAGES-2:0], inr_q};
  end

  // CORDIC chains for the horizontal and vertical angles
  side_t             sd;
  logic [NORM_W:0]   rad;
  cord_t             h_chain [CORDIC_STAGES+1];
  cord_t             v_chain [CORDIC_STAGES+1];
  tag_t              tag_d;
  tag_t              tag_line_q [CORDIC_STAGES];

  assign sd  = side_line_q[SQ_STAGES-1];
  assign rad = sq_chain[SQ_STAGES].res[NORM_W:0];

  always_comb begin
    h_chain[0].x = CW'(sd.mx);
    h_chain[0].y = sd.sy ? CW'(0) - CW'(sd.my) : CW'(sd.my);
    h_chain[0].z = '0;
    v_chain[0].x = CW'(rad);
    v_chain[0].y = sd.sz ? CW'(0) - CW'(sd.mz) : CW'(sd.mz);
    v_chain[0].z = '0;
    tag_d.inr    = inr_sq_q[SQ_STAGES-1];
    tag_d.h_zero = (sd.mx == '0) && (sd.my == '0);
    tag_d.h_xneg = sd.sx;
    tag_d.h_ypos = !sd.sy;
    tag_d.v_zero = (rad == '0) && (sd.mz == '0);
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cd
    pisc_cordic_cell #(
      .STAGE(k)
    ) u_h_cell (
      .clk_i(clk_i),
      .in_i (h_chain[k]),
      .out_o(h_chain[k+1])
    );
    pisc_cordic_cell #(
      .STAGE(k)
    ) u_v_cell (
      .clk_i(clk_i),
      .in_i (v_chain[k]),
      .out_o(v_chain[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    tag_line_q[0] <= tag_d;
    for (int k = 1; k < CORDIC_STAGES; k++) begin
      tag_line_q[k] <= tag_line_q[k-1];
    end
  end

  // Quadrant fix-up, rounding and limit tests
  function automatic logic signed [AW-1:0] fin_angle(input logic [ZW-1:0] z,
                                                     input logic zero,
                                                     input logic xneg,
                                                     input logic ypos);
    logic signed [ZW:0] zs, a, pi_v, rnd;
    zs   = (ZW+1)'($signed(z));
    pi_v = (ZW+1)'(ANG_PI);
    if (xneg) begin
      a = ypos ? pi_v - zs : -pi_v - zs;
    end else begin
      a = zs;
    end
    rnd = (a + (ZW+1)'(1 << (FRAC_EXTRA - 1))) >>> FRAC_EXTRA;
    return zero ? '0 : AW'(rnd);
  endfunction

  tag_t                   tl;
  logic signed [AW-1:0]   h_q, v_q;
  logic                   f1_inr_q;
  logic signed [CMPA_W-1:0] hx, vx, habs, vabs, lo, hi;
  logic                   hit;

  assign tl = tag_line_q[CORDIC_STAGES-1];

  always_ff @(posedge clk_i) begin
    h_q      <= fin_angle(h_chain[CORDIC_STAGES].z, tl.h_zero, tl.h_xneg, tl.h_ypos);
    v_q      <= fin_angle(v_chain[CORDIC_STAGES].z, tl.v_zero, 1'b0, 1'b1);
    f1_inr_q <= tl.inr;
  end

  always_comb begin
    hx   = CMPA_W'(h_q);
    vx   = CMPA_W'(v_q);
    lo   = CMPA_W'(first_angle_q);
    hi   = CMPA_W'(second_angle_q);
    habs = (hx < 0) ? -hx : hx;
    vabs = (vx < 0) ? -vx : vx;
    unique case (mode_e'(mode_q))
      MODE_SPHERE: hit = 1'b1;
      MODE_SECTOR: hit = (hx >= lo) && (hx <= hi);
      default:     hit = (habs <= lo) && (vabs <= hi);
    endcase
    covered_d = f1_vld_q && f1_inr_q && hit;
  end

  assign busy_o    = 1'b0;
  assign done_o    = done_q;
  assign covered_o = covered_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o)
    else $error("result strobe missing at the fixed latency");

  a_range_gate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f1_vld_q && !f1_inr_q) |=> !covered_o)
    else $error("point outside the range shell reported as covered");

  a_idle_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !covered_o)
    else $error("covered high without a result strobe");

  a_angle_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1_vld_q |-> (h_q >= -ANG_HALF && h_q <= ANG_HALF && v_q >= -ANG_HALF
                  && v_q <= ANG_HALF))
    else $error("angle outside half a turn");

endmodule
